### rtl/assert_macros.svh
// Assertion macros shared by the round-robin completion time RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RRCT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rrct_pkg.sv
// Types, constants and control word layout for the round-robin completion time block.
`timescale 1ns / 1ps
package rrct_pkg;

   localparam int MAX_PROCS    = 16;
   localparam int TIME_BITS    = 16;
   localparam int IDX_BITS     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_PROCS + 1);
   localparam int QUANTUM_BITS = 16;
   localparam int CT_BITS      = 20;
   localparam int DIFF_BITS    = 21;
   localparam int JOB_NUM_BITS = 5;
   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = QUANTUM_BITS'(4);

   // Microprogram addresses.
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_INIT,
      STEP_SWEEP,
      STEP_SERVE,
      STEP_CHECK,
      STEP_EMIT,
      STEP_DONE
   } step_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_LOAD,
      DP_INIT,
      DP_SWEEP,
      DP_SERVE,
      DP_EMIT,
      DP_FINISH
   } dp_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ_LAST,
      COND_IDX_LAST,
      COND_PENDING
   } cond_type;

   typedef struct packed {
      dp_op_type  dp_op;
      idx_op_type idx_op;
      cond_type   cond;
      logic       wait_out;  // freeze step until the result register is free
      logic       stay;      // on false condition: 1 = repeat step, 0 = fall through
      step_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic accept_last;
      logic idx_last;
      logic pending;
      logic out_free;
   } status_type;

endpackage

### rtl/rrct_ucode_rom.sv
// Microprogram table: one control word per sequencer step.
`timescale 1ns / 1ps
module rrct_ucode_rom (
   input  rrct_pkg::step_type      addr,
   output rrct_pkg::ctrl_word_type word
);
   import rrct_pkg::*;

   always_comb begin
      case (addr)
         STEP_IDLE:  word = '{DP_LOAD,   IDX_CLEAR, COND_REQ_LAST, 1'b0, 1'b1, STEP_INIT};
         STEP_INIT:  word = '{DP_INIT,   IDX_INC,   COND_IDX_LAST, 1'b0, 1'b1, STEP_SWEEP};
         STEP_SWEEP: word = '{DP_SWEEP,  IDX_CLEAR, COND_ALWAYS,   1'b0, 1'b0, STEP_SERVE};
         STEP_SERVE: word = '{DP_SERVE,  IDX_INC,   COND_IDX_LAST, 1'b0, 1'b1, STEP_CHECK};
         STEP_CHECK: word = '{DP_NONE,   IDX_CLEAR, COND_PENDING,  1'b0, 1'b0, STEP_SWEEP};
         STEP_EMIT:  word = '{DP_EMIT,   IDX_INC,   COND_IDX_LAST, 1'b1, 1'b1, STEP_DONE};
         STEP_DONE:  word = '{DP_FINISH, IDX_CLEAR, COND_ALWAYS,   1'b0, 1'b0, STEP_IDLE};
         default:    word = '{DP_NONE,   IDX_CLEAR, COND_ALWAYS,   1'b0, 1'b0, STEP_IDLE};
      endcase
   end

endmodule

### rtl/rrct_sequencer.sv
// Step counter with conditional jumps driven by the microprogram table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrct_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  rrct_pkg::ctrl_word_type ctrl,
   input  rrct_pkg::status_type    status,
   output rrct_pkg::step_type      upc
);
   import rrct_pkg::*;

   step_type upc_ff;
   step_type upc_in;
   logic     cond_true;
   logic     frozen;

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_REQ_LAST: cond_true = status.accept_last;
         COND_IDX_LAST: cond_true = status.idx_last;
         COND_PENDING:  cond_true = status.pending;
         default:       cond_true = 1'b1;
      endcase
   end

   assign frozen = ctrl.wait_out && !status.out_free;

   always_comb begin
      if (frozen) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = ctrl.target;
      end else if (ctrl.stay) begin
         upc_in = upc_ff;
      end else begin
         upc_in = step_type'(upc_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign upc = upc_ff;

   `RRCT_ASSERT_NEXT(a_done_to_idle, clock, reset, upc_ff == STEP_DONE, upc_ff == STEP_IDLE, "batch end must return to idle")
   `RRCT_ASSERT_NEXT(a_emit_holds, clock, reset, (upc_ff == STEP_EMIT) && !status.out_free, upc_ff == STEP_EMIT, "emit step advanced while result slot busy")

endmodule

### rtl/rrct_datapath.sv
// Job stores, time accumulator, quantum register and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrct_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rrct_pkg::ctrl_word_type             ctrl,
   output rrct_pkg::status_type                status,
   input  logic                                csr_wr_en,
   input  logic [rrct_pkg::QUANTUM_BITS-1:0]   csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rrct_pkg::TIME_BITS-1:0]      req_arrival_time,
   input  logic [rrct_pkg::TIME_BITS-1:0]      req_burst_time,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rrct_pkg::JOB_NUM_BITS-1:0]   rsp_job_number,
   output logic [rrct_pkg::CT_BITS-1:0]        rsp_completion_time,
   output logic signed [rrct_pkg::DIFF_BITS-1:0] rsp_turnaround_time,
   output logic signed [rrct_pkg::DIFF_BITS-1:0] rsp_waiting_time,
   output logic                                rsp_overflow,
   output logic                                rsp_last_result
);
   import rrct_pkg::*;

   // job stores, undefined until written
   logic [TIME_BITS-1:0] arrival_ff    [MAX_PROCS];
   logic [TIME_BITS-1:0] burst_ff      [MAX_PROCS];
   logic [TIME_BITS-1:0] remaining_ff  [MAX_PROCS];
   logic [CT_BITS-1:0]   completion_ff [MAX_PROCS];

   logic [CNT_BITS-1:0]     count_ff,    count_in;
   logic [IDX_BITS-1:0]     idx_ff,      idx_in;
   logic [CT_BITS-1:0]      time_ff,     time_in;
   logic                    pending_ff,  pending_in;
   logic                    overflow_ff, overflow_in;
   logic [QUANTUM_BITS-1:0] quantum_ff,  quantum_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [JOB_NUM_BITS-1:0] rsp_job_ff;
   logic [CT_BITS-1:0]      rsp_comp_ff;
   logic [DIFF_BITS-1:0]    rsp_ta_ff;
   logic [DIFF_BITS-1:0]    rsp_wt_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    has_room;
   logic                    out_free;
   logic                    step_en;
   logic                    idx_last;
   logic [TIME_BITS-1:0]    rem_rd;
   logic [TIME_BITS-1:0]    q_eff;
   logic                    over_q;
   logic [TIME_BITS-1:0]    slice;
   logic [CT_BITS-1:0]      time_sum;
   logic                    load_wr;
   logic                    rem_wr;
   logic                    comp_wr;
   logic [TIME_BITS-1:0]    rem_in;
   logic [CT_BITS-1:0]      comp_in;
   logic [DIFF_BITS-1:0]    ta_calc;
   logic [DIFF_BITS-1:0]    wt_calc;

   assign req_stall = reset || (ctrl.dp_op != DP_LOAD);
   assign accept    = req_valid && !req_stall;
   assign has_room  = count_ff < CNT_BITS'(MAX_PROCS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = !(ctrl.wait_out && !out_free);
   assign idx_last  = CNT_BITS'(idx_ff) == (count_ff - CNT_BITS'(1));

   assign status = '{accept_last: accept && req_last,
                     idx_last:    idx_last,
                     pending:     pending_ff,
                     out_free:    out_free};

   // one round-robin turn: slice is min(remaining, quantum)
   assign rem_rd   = remaining_ff[idx_ff];
   assign q_eff    = (quantum_ff == '0) ? TIME_BITS'(1) : TIME_BITS'(quantum_ff);
   assign over_q   = rem_rd > q_eff;
   assign slice    = over_q ? q_eff : rem_rd;
   assign time_sum = time_ff + CT_BITS'(slice);

   assign ta_calc = DIFF_BITS'(completion_ff[idx_ff]) - DIFF_BITS'(arrival_ff[idx_ff]);
   assign wt_calc = ta_calc - DIFF_BITS'(burst_ff[idx_ff]);

   always_comb begin
      count_in     = count_ff;
      time_in      = time_ff;
      pending_in   = pending_ff;
      overflow_in  = overflow_ff;
      quantum_in   = csr_wr_en ? csr_wr_data : quantum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      load_wr      = 1'b0;
      rem_wr       = 1'b0;
      comp_wr      = 1'b0;
      rem_in       = burst_ff[idx_ff];
      comp_in      = '0;

      case (ctrl.dp_op)
         DP_LOAD: begin
            if (accept) begin
               if (has_room) begin
                  load_wr  = 1'b1;
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end
         DP_INIT: begin
            rem_wr  = 1'b1;
            comp_wr = 1'b1;
            time_in = '0;
         end
         DP_SWEEP: begin
            pending_in = 1'b0;
         end
         DP_SERVE: begin
            if (rem_rd != '0) begin
               pending_in = 1'b1;
               time_in    = time_sum;
               rem_wr     = 1'b1;
               rem_in     = rem_rd - slice;
               comp_wr    = !over_q;
               comp_in    = time_sum;
            end
         end
         DP_EMIT: begin
            if (step_en) begin
               rsp_valid_in = 1'b1;
            end
         end
         DP_FINISH: begin
            count_in    = '0;
            time_in     = '0;
            overflow_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (!step_en) begin
         idx_in = idx_ff;
      end else begin
         case (ctrl.idx_op)
            IDX_HOLD:  idx_in = idx_ff;
            IDX_CLEAR: idx_in = '0;
            IDX_INC:   idx_in = idx_ff + IDX_BITS'(1);
            default:   idx_in = idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         time_ff      <= '0;
         pending_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         time_ff      <= time_in;
         pending_ff   <= pending_in;
         overflow_ff  <= overflow_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         arrival_ff[count_ff[IDX_BITS-1:0]] <= req_arrival_time;
         burst_ff[count_ff[IDX_BITS-1:0]]   <= req_burst_time;
      end
      if (rem_wr) begin
         remaining_ff[idx_ff] <= rem_in;
      end
      if (comp_wr) begin
         completion_ff[idx_ff] <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.dp_op == DP_EMIT) && step_en) begin
         rsp_job_ff  <= JOB_NUM_BITS'(idx_ff) + JOB_NUM_BITS'(1);
         rsp_comp_ff <= completion_ff[idx_ff];
         rsp_ta_ff   <= ta_calc;
         rsp_wt_ff   <= wt_calc;
         rsp_ovf_ff  <= overflow_ff;
         rsp_last_ff <= idx_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_number      = rsp_job_ff;
   assign rsp_completion_time = rsp_comp_ff;
   assign rsp_turnaround_time = $signed(rsp_ta_ff);
   assign rsp_waiting_time    = $signed(rsp_wt_ff);
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_last_result     = rsp_last_ff;

   `RRCT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_BITS'(MAX_PROCS), "job count beyond capacity")
   `RRCT_ASSERT(a_serve_nonempty, clock, reset, (ctrl.dp_op != DP_SERVE) || (count_ff != '0), "schedule running on an empty batch")

endmodule

### rtl/round_robin_completion_times.sv
// Top level of the round-robin completion time block.
`timescale 1ns / 1ps
// Usage:
//   Jobs enter on the req_ channel (valid/stall), one request per job, in load
//   order. A request is taken in the cycle it is offered while the block is
//   loading. Up to MAX_PROCS jobs are held; later jobs of the same batch are
//   dropped and the batch's results carry the overflow flag. The request with
//   req_last set closes the batch and starts the schedule; req_stall stays high
//   until the done step, which follows the emit of its last result, closes the batch.
//   After the closing request the block sets up each stored job, then serves R
//   rounds (R = largest ceil(burst / quantum) plus one empty round), one job
//   turn at a time in the datapath's single adder, then emits results and closes.
//   Results leave on the rsp_ channel, one per stored job in load order, the
//   final one marked by rsp_last_result. rsp_stall freezes the emit step; the
//   result register holds its payload while stalled. The quantum is written
//   through csr_wr_en / csr_wr_data; the user must write it only while idle,
//   as the block does not enforce this. Zero acts as one. Reset (synchronous)
//   empties the batch, sets quantum to 4 and drops any pending result; job
//   stores are not cleared.
module round_robin_completion_times (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [rrct_pkg::QUANTUM_BITS-1:0]     csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rrct_pkg::TIME_BITS-1:0]        req_arrival_time,
   input  logic [rrct_pkg::TIME_BITS-1:0]        req_burst_time,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rrct_pkg::JOB_NUM_BITS-1:0]     rsp_job_number,
   output logic [rrct_pkg::CT_BITS-1:0]          rsp_completion_time,
   output logic signed [rrct_pkg::DIFF_BITS-1:0] rsp_turnaround_time,
   output logic signed [rrct_pkg::DIFF_BITS-1:0] rsp_waiting_time,
   output logic                                  rsp_overflow,
   output logic                                  rsp_last_result
);
   import rrct_pkg::*;

   step_type      upc;     // current microprogram step
   ctrl_word_type ctrl;    // control word for this step
   status_type    status;  // datapath flags for branching

   rrct_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .upc    (upc)
   );

   // Program: idle/load -> init -> (sweep -> serve* -> check)+ -> emit* -> done
   rrct_ucode_rom u_rom (
      .addr (upc),
      .word (ctrl)
   );

   rrct_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_job_number      (rsp_job_number),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

### dv/tb_round_robin_completion_times.sv
// Self-checking testbench for the round-robin completion time block.
`timescale 1ns / 1ps
module tb_round_robin_completion_times;
   import rrct_pkg::*;

   // Settle time after the last result: the block still spends its done step
   // closing the batch, so this leaves margin before a quantum write.
   localparam int SETTLE_CYCLES = 8;
   // Long receiver hold-off used to back the block up into its request side.
   localparam int LONG_HOLD     = 300;
   // Total requests to send before the run winds down.
   localparam int ITEM_TARGET   = 330;
   // Watchdog time for the whole run, in ns; reaching it ends the run as failed.
   localparam int RUN_LIMIT_NS  = 5_000_000;

   typedef struct {
      logic [JOB_NUM_BITS-1:0]     job_number;
      logic [CT_BITS-1:0]          finish_stamp;
      logic signed [DIFF_BITS-1:0] turnaround_time;
      logic signed [DIFF_BITS-1:0] wait_span;
      logic                        overflow;
      logic                        last_result;
   } job_report_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic [QUANTUM_BITS-1:0]     csr_wr_data = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [TIME_BITS-1:0]        req_arrival_time = '0;
   logic [TIME_BITS-1:0]        req_burst_time = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [JOB_NUM_BITS-1:0]     rsp_job_number;
   logic [CT_BITS-1:0]          rsp_completion_time;
   logic signed [DIFF_BITS-1:0] rsp_turnaround_time;
   logic signed [DIFF_BITS-1:0] rsp_waiting_time;
   logic                        rsp_overflow;
   logic                        rsp_last_result;

   // Shadow of the block: quantum register plus the batch being loaded.
   logic [QUANTUM_BITS-1:0] quantum_setting = QUANTUM_RESET;
   logic [TIME_BITS-1:0]    batch_arrival [MAX_PROCS];
   logic [TIME_BITS-1:0]    batch_burst [MAX_PROCS];
   int                      batch_size = 0;
   bit                      batch_dropped = 1'b0;
   job_report_type          expected_reports [$];

   int mismatch_count = 0;
   int jobs_sent      = 0;
   bit hold_req       = 1'b0; // toggled to ask the receiver for a long hold-off
   bit hold_seen      = 1'b0; // receiver's copy of hold_req
   int hold_left      = 0;   // long receiver hold-off, counted down below
   int stall_left     = 0;   // remainder of a random receiver stall
   bit quiet_req      = 1'b0; // no gaps between requests
   bit quiet_rsp      = 1'b0; // receiver adds no new random stalls

   round_robin_completion_times dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_job_number      (rsp_job_number),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_result     (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Round-robin service of the stored batch. Every job is ready at time 0;
   // each sweep gives every unfinished job up to one slice, in load order.
   function automatic void schedule_batch();
      int unsigned    left [MAX_PROCS];
      int unsigned    finish [MAX_PROCS];
      int unsigned    slice;
      int unsigned    elapsed;
      bit             busy;
      longint         turnaround;
      longint         waiting;
      job_report_type report;
      slice   = (quantum_setting == 0) ? 1 : quantum_setting;  // zero acts as one
      elapsed = 0;
      for (int i = 0; i < batch_size; i++) begin
         left[i]   = batch_burst[i];
         finish[i] = 0;   // zero-burst jobs report completion 0
      end
      busy = 1'b1;
      while (busy) begin
         busy = 1'b0;
         for (int i = 0; i < batch_size; i++) begin
            if (left[i] != 0) begin
               busy = 1'b1;
               if (left[i] > slice) begin
                  elapsed += slice;
                  left[i] -= slice;
               end else begin
                  elapsed  += left[i];
                  left[i]   = 0;
                  finish[i] = elapsed;
               end
            end
         end
      end
      for (int i = 0; i < batch_size; i++) begin
         turnaround = longint'(finish[i]) - longint'(batch_arrival[i]);
         waiting    = turnaround - longint'(batch_burst[i]);
         report.job_number      = JOB_NUM_BITS'(i + 1);
         report.finish_stamp    = CT_BITS'(finish[i]);
         report.turnaround_time = DIFF_BITS'(turnaround);
         report.wait_span       = DIFF_BITS'(waiting);
         report.overflow        = batch_dropped;
         report.last_result     = (i + 1 == batch_size);
         expected_reports.push_back(report);
      end
      batch_size    = 0;
      batch_dropped = 1'b0;
   endfunction

   // Track one accepted request: store it, or drop it once the batch is full.
   function automatic void load_job(input logic [TIME_BITS-1:0] arrival,
                                    input logic [TIME_BITS-1:0] burst,
                                    input logic last_job);
      if (batch_size < MAX_PROCS) begin
         batch_arrival[batch_size] = arrival;
         batch_burst[batch_size]   = burst;
         batch_size++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (last_job) schedule_batch();
   endfunction

   // Offer one request and wait for it to be taken. Valid is left high on
   // return so a back-to-back request keeps it up; drain_batches lowers it.
   task automatic send_job(input logic [TIME_BITS-1:0] arrival,
                           input logic [TIME_BITS-1:0] burst,
                           input logic last_job);
      int gap;
      gap = quiet_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arrival;
      req_burst_time   <= burst;
      req_last         <= last_job;
      do @(posedge clock); while (req_stall);
      load_job(arrival, burst, last_job);
      jobs_sent++;
   endtask

   // Stop requesting, wait for every expected result, then let the block
   // close the batch before anything else touches it.
   task automatic drain_batches();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_quantum(input logic [QUANTUM_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      quantum_setting = value;
   endtask

   // Bursts stay within a few slices of the quantum so runs stay short;
   // a quantum near the top still spans the full burst range.
   function automatic logic [TIME_BITS-1:0] pick_burst();
      int unsigned cap;
      int          roll;
      cap = (quantum_setting == 0) ? 1 : quantum_setting;
      cap = cap * 8;
      if (cap > 65535) cap = 65535;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return TIME_BITS'(cap);
      return TIME_BITS'($urandom_range(0, cap));
   endfunction

   function automatic logic [TIME_BITS-1:0] pick_arrival();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return TIME_BITS'($urandom_range(0, 65535));
   endfunction

   // One batch of random jobs; sizes past MAX_PROCS exercise dropping.
   task automatic random_batch(input int jobs);
      for (int k = 0; k < jobs; k++)
         send_job(pick_arrival(), pick_burst(), k == jobs - 1);
   endtask

   // Reset quantum of 4; an arrival past completion gives negative turnaround.
   task automatic test_reset_quantum();
      send_job(16'd0, 16'd10, 1'b0);
      send_job(16'd5, 16'd4, 1'b0);
      send_job(16'hFFFF, 16'd7, 1'b1);
      drain_batches();
   endtask

   // Zero bursts report completion 0, including on the closing request.
   task automatic test_zero_burst();
      write_quantum(16'd3);
      send_job(16'd7, 16'd0, 1'b0);
      send_job(16'd0, 16'd5, 1'b0);
      send_job(16'hFFFF, 16'd0, 1'b1);
      drain_batches();
   endtask

   // Full batch at the largest times, then one more request marked last that
   // gets dropped yet still starts the schedule and flags overflow.
   task automatic test_full_batch_overflow();
      write_quantum(16'hFFFF);
      for (int k = 0; k < MAX_PROCS; k++)
         send_job((k % 2) ? 16'hFFFF : 16'd0, 16'hFFFF, 1'b0);
      send_job(16'hFFFF, 16'hFFFF, 1'b1);
      drain_batches();
   endtask

   // A quantum of zero behaves as one.
   task automatic test_zero_quantum();
      write_quantum(16'd0);
      send_job(16'd1, 16'd3, 1'b0);
      send_job(16'd2, 16'd1, 1'b1);
      drain_batches();
   endtask

   // Hold the result side off while requests keep coming, so a finished
   // batch blocks the next one on req_stall.
   task automatic test_result_backpressure();
      write_quantum(16'd2);
      quiet_req = 1'b1;
      hold_req <= !hold_req;
      random_batch(6);
      random_batch(5);
      random_batch(12);
      drain_batches();
      quiet_req = 1'b0;
   endtask

   // Phases of random batches, each under a fresh quantum and idle pattern.
   task automatic test_random_batches();
      int mode;
      int batches;
      int size_roll;
      while (jobs_sent < ITEM_TARGET) begin
         mode = $urandom_range(0, 3);
         case (mode)
            0: write_quantum(16'd1);
            1: write_quantum(16'hFFFF);
            2: write_quantum(QUANTUM_BITS'($urandom_range(2, 16)));
            default: write_quantum(QUANTUM_BITS'($urandom_range(1, 65535)));
         endcase
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         batches   = $urandom_range(2, 4);
         for (int b = 0; b < batches && jobs_sent < ITEM_TARGET; b++) begin
            size_roll = $urandom_range(0, 99);
            if (size_roll < 10) random_batch(1);
            else if (size_roll < 20) random_batch(MAX_PROCS);
            else if (size_roll < 30) random_batch($urandom_range(MAX_PROCS + 1, MAX_PROCS + 4));
            else random_batch($urandom_range(2, MAX_PROCS - 1));
            // Sometimes the sender waits for every result before going on.
            if ($urandom_range(0, 3) == 0) drain_batches();
         end
         drain_batches();
      end
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
   endtask

   // Receiver: long hold-off when requested, else random stalls.
   always @(posedge clock) begin
      int gap;
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (quiet_rsp) begin
         rsp_stall <= 1'b0;
      end else begin
         gap = pick_gap();
         rsp_stall  <= (gap != 0);
         stall_left <= (gap > 0) ? gap - 1 : 0;
      end
   end

   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Every accepted result is checked against the oldest expected report.
   always @(posedge clock) begin
      job_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("result for job %0d with no request pending", rsp_job_number);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("job_number", want.job_number, rsp_job_number);
            compare_field("rsp_completion_time", want.finish_stamp, rsp_completion_time);
            compare_field("turnaround_time", want.turnaround_time, rsp_turnaround_time);
            compare_field("rsp_waiting_time", want.wait_span, rsp_waiting_time);
            compare_field("overflow", want.overflow, rsp_overflow);
            compare_field("last_result", want.last_result, rsp_last_result);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_quantum();
      test_zero_burst();
      test_full_batch_overflow();
      test_zero_quantum();
      test_result_backpressure();
      test_random_batches();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/rrct_pkg.sv
rtl/rrct_ucode_rom.sv
rtl/rrct_sequencer.sv
rtl/rrct_datapath.sv
rtl/round_robin_completion_times.sv
dv/tb_round_robin_completion_times.sv
